/* rtl/block_change_detect_dilate_assert.svh */
// Assertion macros shared by the change detect and dilate block.
`ifndef BLOCK_CHANGE_DETECT_DILATE_ASSERT_SVH
`define BLOCK_CHANGE_DETECT_DILATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define CDD_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define CDD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CDD_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define CDD_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

/* rtl/bcdd_pkg.sv */
// Package with shared types, codes and constants of the change detect block.
package bcdd_pkg;

   // Default grid limits.
   localparam int MAX_COLUMNS_DEF = 128;
   localparam int MAX_ROWS_DEF    = 128;

   // Word widths on the streams and the configuration port.
   localparam int REQ_W      = 144;
   localparam int RSP_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int DIM_W      = 9;
   localparam int MAG_W      = 11;

   // Command codes.
   localparam logic [1:0] CMD_COMPARE    = 2'd0;
   localparam logic [1:0] CMD_MARK_ALL   = 2'd1;
   localparam logic [1:0] CMD_READ_CLEAR = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_COLUMNS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_ROWS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd2;

   // Register reset values.
   localparam logic [7:0]            COLUMNS_RESET   = 8'd80;
   localparam logic [7:0]            ROWS_RESET      = 8'd60;
   localparam logic [MAG_W-1:0]      THRESHOLD_RESET = 11'd64;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic calc_sum;
      logic calc_level;
      logic rd_en;
      logic load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic touch;
      logic row_last;
      logic rsp_free;
   } dp_status_type;

endpackage

/* rtl/bcdd_csr.sv */
// Configuration registers with the clamped grid size.
module bcdd_csr #(
   parameter int MAX_COLUMNS = bcdd_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = bcdd_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bcdd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bcdd_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [bcdd_pkg::DIM_W-1:0]      cols_eff,
   output logic [bcdd_pkg::DIM_W-1:0]      rows_eff,
   output logic [bcdd_pkg::MAG_W-1:0]      threshold
);
   import bcdd_pkg::*;

   logic [7:0]       columns_ff;
   logic [7:0]       rows_ff;
   logic [MAG_W-1:0] threshold_ff;

   // Writes are taken in every cycle.
   assign csr_ready = 1'b1;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BLOCK_COLUMNS:    columns_ff   <= csr_data[7:0];
            REG_BLOCK_ROWS:       rows_ff      <= csr_data[7:0];
            REG_CHANGE_THRESHOLD: threshold_ff <= csr_data[MAG_W-1:0];
            default: ;
         endcase
      end
   end

   // A size of zero counts as one, and a size above the maximum as the maximum.
   always_comb begin
      if (columns_ff == 8'd0) begin
         cols_eff = DIM_W'(1);
      end else if ({1'b0, columns_ff} > DIM_W'(MAX_COLUMNS)) begin
         cols_eff = DIM_W'(MAX_COLUMNS);
      end else begin
         cols_eff = {1'b0, columns_ff};
      end
      if (rows_ff == 8'd0) begin
         rows_eff = DIM_W'(1);
      end else if ({1'b0, rows_ff} > DIM_W'(MAX_ROWS)) begin
         rows_eff = DIM_W'(MAX_ROWS);
      end else begin
         rows_eff = {1'b0, rows_ff};
      end
   end

   assign threshold = threshold_ff;

endmodule

/* rtl/bcdd_ctrl.sv */
// Sequencer that steps one word through sum, level, row updates and result.
module bcdd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output bcdd_pkg::dp_cmd_type    dp_cmd,
   input  bcdd_pkg::dp_status_type dp_status
);
   import bcdd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_LEVEL,
      ST_ROWS,
      ST_FLUSH,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      accept;

   assign accept     = req_tvalid && ready_ff;
   assign req_tready = ready_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dp_cmd.load_item = 1'b1;
               state_in         = ST_SUM;
            end
         end
         ST_SUM: begin
            dp_cmd.calc_sum = 1'b1;
            state_in        = ST_LEVEL;
         end
         ST_LEVEL: begin
            dp_cmd.calc_level = 1'b1;
            state_in          = dp_status.touch ? ST_ROWS : ST_DONE;
         end
         ST_ROWS: begin
            dp_cmd.rd_en = 1'b1;
            if (dp_status.row_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (dp_status.rsp_free) begin
               dp_cmd.load_rsp = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and the registered ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

endmodule

/* rtl/bcdd_datapath.sv */
// Datapath: difference magnitude, mark level, row-wide flag memory and result word.
module bcdd_datapath #(
   parameter int MAX_COLUMNS = bcdd_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = bcdd_pkg::MAX_ROWS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bcdd_pkg::dp_cmd_type         dp_cmd,
   output bcdd_pkg::dp_status_type      dp_status,
   input  logic [bcdd_pkg::REQ_W-1:0]   req_tdata,
   input  logic [bcdd_pkg::DIM_W-1:0]   cols_eff,
   input  logic [bcdd_pkg::DIM_W-1:0]   rows_eff,
   input  logic [bcdd_pkg::MAG_W-1:0]   threshold,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [bcdd_pkg::RSP_W-1:0]   rsp_tdata
);
   import bcdd_pkg::*;

   localparam int CW = $clog2(MAX_COLUMNS);
   localparam int RW = $clog2(MAX_ROWS);

   typedef logic [MAX_COLUMNS-1:0] row_type;

   // Sum of the four bytes of a packed word.
   function automatic logic [9:0] byte_sum(input logic [31:0] w);
      logic [9:0] s;
      s = 10'd0;
      for (int i = 0; i < 4; i++) begin
         s = s + {2'b00, w[8*i +: 8]};
      end
      return s;
   endfunction

   // Item registers.
   logic [1:0]  op_ff;
   logic [6:0]  bx_ff;
   logic [6:0]  by_ff;
   logic [31:0] new_up_ff;
   logic [31:0] new_lo_ff;
   logic [31:0] old_up_ff;
   logic [31:0] old_lo_ff;

   // Work registers.
   logic [MAG_W-1:0] mag_ff;
   logic [1:0]       level_ff;
   logic [DIM_W-1:0] row_ff;
   logic [DIM_W-1:0] row_end_ff;
   row_type          onehot_ff;
   row_type          center_mask_ff;
   row_type          side_mask_ff;
   logic [2:0]       phase_ff;
   logic             flag_ff;

   // Flag memory and its per-row state.
   row_type              flag_mem [MAX_ROWS];
   row_type              rd_data_ff;
   logic                 rd_pend_ff;
   logic [DIM_W-1:0]     wr_row_ff;
   logic [MAX_ROWS-1:0]  valid_ff;
   logic [MAX_ROWS-1:0]  fill_ff;

   // Result register.
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   // Combinational terms.
   logic [MAG_W-1:0] sum_new;
   logic [MAG_W-1:0] sum_old;
   logic [DIM_W-1:0] x9;
   logic [DIM_W-1:0] y9;
   logic             in_grid;
   logic [MAG_W:0]   mag12;
   logic [MAG_W:0]   thr12;
   logic [1:0]       level_in;
   logic             wide;
   logic [DIM_W-1:0] row_start;
   logic [DIM_W-1:0] row_end;
   row_type          onehot;
   row_type          left_mask;
   row_type          right_mask;
   logic             advance;
   logic [RW-1:0]    rd_idx;
   logic [RW-1:0]    wr_idx;
   row_type          old_row;
   row_type          new_row;

   // Magnitude of the summed differences.
   assign sum_new = {1'b0, byte_sum(new_up_ff)} + {1'b0, byte_sum(new_lo_ff)};
   assign sum_old = {1'b0, byte_sum(old_up_ff)} + {1'b0, byte_sum(old_lo_ff)};

   // Position and mark level.
   assign x9      = {2'b00, bx_ff};
   assign y9      = {2'b00, by_ff};
   assign in_grid = (x9 < cols_eff) && (y9 < rows_eff);
   assign mag12   = {1'b0, mag_ff};
   assign thr12   = {1'b0, threshold};

   always_comb begin
      level_in = 2'd0;
      if (op_ff == CMD_COMPARE && in_grid) begin
         if (mag12 >= thr12 + (MAG_W+1)'(8)) begin
            level_in = 2'd3;
         end else if (mag12 >= thr12 + (MAG_W+1)'(4)) begin
            level_in = 2'd2;
         end else if (mag12 >= thr12) begin
            level_in = 2'd1;
         end
      end
   end

   // Rows touched: the block's own row, and its neighbors once edges are marked.
   assign wide      = level_in[1];
   assign row_start = (wide && y9 != '0) ? y9 - DIM_W'(1) : y9;
   assign row_end   = (wide && (y9 + DIM_W'(1) < rows_eff)) ? y9 + DIM_W'(1) : y9;

   // Column masks inside the grid.
   assign onehot     = {{(MAX_COLUMNS-1){1'b0}}, 1'b1} << x9[CW-1:0];
   assign left_mask  = (x9 != '0) ? (onehot >> 1) : '0;
   assign right_mask = (x9 + DIM_W'(1) < cols_eff) ? (onehot << 1) : '0;

   assign advance = (op_ff == CMD_COMPARE) && in_grid &&
                    (x9 == cols_eff - DIM_W'(1)) && (y9 == rows_eff - DIM_W'(1));

   assign dp_status.touch    = (op_ff == CMD_COMPARE && level_in != 2'd0) ||
                               (op_ff == CMD_READ_CLEAR && in_grid);
   assign dp_status.row_last = (row_ff == row_end_ff);
   assign dp_status.rsp_free = !rsp_valid_ff || rsp_tready;

   // Read-modify-write of one row; a row never written reads as its fill value.
   assign rd_idx  = row_ff[RW-1:0];
   assign wr_idx  = wr_row_ff[RW-1:0];
   assign old_row = valid_ff[wr_idx] ? rd_data_ff : {MAX_COLUMNS{fill_ff[wr_idx]}};

   always_comb begin
      if (op_ff == CMD_READ_CLEAR) begin
         new_row = old_row & ~onehot_ff;
      end else if (wr_row_ff == y9) begin
         new_row = old_row | center_mask_ff;
      end else begin
         new_row = old_row | side_mask_ff;
      end
   end

   // Item and work registers.
   always_ff @(posedge clock) begin
      if (dp_cmd.load_item) begin
         op_ff     <= req_tdata[1:0];
         bx_ff     <= req_tdata[8:2];
         by_ff     <= req_tdata[15:9];
         new_up_ff <= req_tdata[47:16];
         new_lo_ff <= req_tdata[79:48];
         old_up_ff <= req_tdata[111:80];
         old_lo_ff <= req_tdata[143:112];
      end
      if (dp_cmd.calc_sum) begin
         mag_ff <= (sum_new >= sum_old) ? sum_new - sum_old : sum_old - sum_new;
      end
      if (dp_cmd.calc_level) begin
         level_ff       <= level_in;
         row_end_ff     <= row_end;
         onehot_ff      <= onehot;
         center_mask_ff <= onehot | (wide ? (left_mask | right_mask) : '0);
         side_mask_ff   <= onehot | ((level_in == 2'd3) ? (left_mask | right_mask) : '0);
      end
      if (dp_cmd.calc_level) begin
         row_ff <= row_start;
      end else if (dp_cmd.rd_en) begin
         row_ff <= row_ff + DIM_W'(1);
      end
      if (dp_cmd.rd_en) begin
         wr_row_ff <= row_ff;
      end
      if (dp_cmd.load_item) begin
         flag_ff <= 1'b0;
      end else if (rd_pend_ff && op_ff == CMD_READ_CLEAR) begin
         flag_ff <= |(old_row & onehot_ff);
      end
   end

   // Flag memory with registered read.
   always_ff @(posedge clock) begin
      if (dp_cmd.rd_en) begin
         rd_data_ff <= flag_mem[rd_idx];
      end
      if (rd_pend_ff) begin
         flag_mem[wr_idx] <= new_row;
      end
   end

   // Row state, phase and write pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         fill_ff    <= '0;
         phase_ff   <= 3'd0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= dp_cmd.rd_en;
         if (dp_cmd.calc_level && op_ff == CMD_MARK_ALL) begin
            valid_ff <= '0;
            fill_ff  <= '1;
         end else if (rd_pend_ff) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (dp_cmd.calc_level && advance) begin
            phase_ff <= phase_ff + 3'd1;
         end
      end
   end

   // Result word: magnitude, mark level, flag value, phase from the lowest bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (dp_cmd.load_rsp) begin
         rsp_data_ff <= {7'd0, phase_ff, flag_ff, level_ff,
                         (op_ff == CMD_COMPARE) ? mag_ff : {MAG_W{1'b0}}};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/block_change_detect_dilate.sv */
// Top level of the block change detector with flag dilation.
// The block keeps one send flag per 8x8 video block in a flag memory of
// MAX_ROWS rows, each MAX_COLUMNS bits wide, plus a 3-bit sampling phase.
// Each request word is handled on its own, and the next one is accepted
// once the result of the previous one has been placed in the output
// register. A compare that marks flags or an in-grid read makes one
// read-modify-write of the flag memory per touched flag row, one to three
// rows; a compare that marks nothing, a mark-all, a read outside the grid
// and an unused command touch no row. Mark-all needs no pass over the
// rows thanks to a per-row valid and fill bit, so no clearing pass follows
// reset and rows never written read as clear until the first mark-all.
`include "block_change_detect_dilate_assert.svh"

module block_change_detect_dilate #(
   parameter int MAX_COLUMNS = bcdd_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = bcdd_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Fields from bit 0: cmd[1:0], block_x[8:2], block_y[15:9], new_upper[47:16],
   // new_lower[79:48], old_upper[111:80], old_lower[143:112].
   input  logic [bcdd_pkg::REQ_W-1:0]      req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0: magnitude[10:0], mark_level[12:11], flag_value[13],
   // phase[16:14], zero fill up to bit 23.
   output logic [bcdd_pkg::RSP_W-1:0]      rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bcdd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bcdd_pkg::CSR_DATA_W-1:0] csr_data
);
   import bcdd_pkg::*;

   dp_cmd_type       dp_cmd;
   dp_status_type    dp_status;
   logic [DIM_W-1:0] cols_eff;
   logic [DIM_W-1:0] rows_eff;
   logic [MAG_W-1:0] threshold;

   // Configuration registers.
   bcdd_csr #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cols_eff  (cols_eff),
      .rows_eff  (rows_eff),
      .threshold (threshold)
   );

   // Sequencer.
   bcdd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

   // Datapath and flag memory.
   bcdd_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .req_tdata  (req_tdata),
      .cols_eff   (cols_eff),
      .rows_eff   (rows_eff),
      .threshold  (threshold),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Only one word is in work at a time.
   `CDD_ASSERT_NEXT(a_one_word_in_work, clock, reset, req_tvalid && req_tready, !req_tready)
   // A nonzero mark level needs a magnitude at or above the threshold.
   `CDD_ASSERT_IMPLY(a_level_needs_threshold, clock, reset, rsp_tvalid && (rsp_tdata[12:11] != 2'd0), rsp_tdata[10:0] >= threshold)
   // A set flag value only comes from a read, which reports no magnitude or level.
   `CDD_ASSERT_IMPLY(a_flag_only_on_read, clock, reset, rsp_tvalid && rsp_tdata[13], rsp_tdata[12:0] == 13'd0)

endmodule
